[hdl/vgu_pkg.sv]
// Shared types and codes of the vector geometry unit.
package vgu_pkg;

   localparam int FUNC_WIDTH   = 3;
   localparam int STATUS_WIDTH = 2;

   typedef enum logic [FUNC_WIDTH-1:0] {
      FUNC_CROSS = 3'd0,
      FUNC_NORM  = 3'd1,
      FUNC_DOT   = 3'd2,
      FUNC_MAG   = 3'd3,
      FUNC_TAN   = 3'd4
   } func_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO_DIV = 2'd1,
      STATUS_SAT      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_SQUARE,
      BACK_ROOT,
      BACK_PREP,
      BACK_DIVIDE,
      BACK_OUTPUT
   } back_state_type;

endpackage

[hdl/vgu_if.sv]
// Request and response channel interfaces of the vector geometry unit.
interface vgu_req_if #(parameter int WORD_WIDTH = 32);
   logic                                valid;
   logic                                ready;
   logic [vgu_pkg::FUNC_WIDTH-1:0]      func;
   logic signed [WORD_WIDTH-1:0]        ax;
   logic signed [WORD_WIDTH-1:0]        ay;
   logic signed [WORD_WIDTH-1:0]        az;
   logic signed [WORD_WIDTH-1:0]        bx;
   logic signed [WORD_WIDTH-1:0]        by;
   logic signed [WORD_WIDTH-1:0]        bz;

   modport source (output valid, func, ax, ay, az, bx, by, bz, input ready);
   modport sink   (input valid, func, ax, ay, az, bx, by, bz, output ready);
endinterface

interface vgu_rsp_if #(parameter int WORD_WIDTH = 32);
   logic                                valid;
   logic                                ready;
   logic signed [WORD_WIDTH-1:0]        rx;
   logic signed [WORD_WIDTH-1:0]        ry;
   logic signed [WORD_WIDTH-1:0]        rz;
   logic [vgu_pkg::STATUS_WIDTH-1:0]    status;

   modport source (output valid, rx, ry, rz, status, input ready);
   modport sink   (input valid, rx, ry, rz, status, output ready);
endinterface

[hdl/vector3_geometry_unit.sv]
// Vector geometry unit: cross, unit normal, dot, magnitude and tangent of Q-format 3-D vectors.
//
// The front end registers each request beat and forms the six cross and three dot products
// in two stages, then writes the cross terms and dot sum into a QUEUE_DEPTH-entry queue.
// The back end takes cross, dot, unknown codes and zero-divisor cases at one beat per
// cycle while the response register is free or being read (the response passes the two
// front stages, the queue and the response register). Magnitude holds the back end for
// the square root, one root bit per cycle; unit normal and tangent hold it for a
// bit-serial sum of squares, the square root and a restoring divide, one bit per cycle
// each, three divide lanes side by side. The front keeps taking beats while the queue
// has room.
module vector3_geometry_unit #(
   parameter int WORD_WIDTH  = 32,
   parameter int FRAC_BITS   = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   vgu_req_if.sink    req_ch,
   vgu_rsp_if.source  rsp_ch
);

   localparam int MW = 2*WORD_WIDTH;
   localparam int DW = vgu_pkg::FUNC_WIDTH + 3*(MW+1) + (MW+2);

   logic                           fr_valid, fr_ready;
   logic [vgu_pkg::FUNC_WIDTH-1:0] fr_func;
   logic signed [MW:0]             fr_c0, fr_c1, fr_c2;
   logic signed [MW+1:0]           fr_d;
   logic                           q_valid, q_ready;
   logic [DW-1:0]                  q_data;

   vgu_front #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .fr_valid (fr_valid),
      .fr_ready (fr_ready),
      .fr_func  (fr_func),
      .fr_c0    (fr_c0),
      .fr_c1    (fr_c1),
      .fr_c2    (fr_c2),
      .fr_d     (fr_d)
   );

   vgu_queue #(
      .DATA_WIDTH (DW),
      .DEPTH      (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fr_valid),
      .wr_ready (fr_ready),
      .wr_data  ({fr_func, fr_c0, fr_c1, fr_c2, fr_d}),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_data  (q_data)
   );

   vgu_back #(
      .WORD_WIDTH (WORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_func  (q_data[DW-1 -: vgu_pkg::FUNC_WIDTH]),
      .q_c0    (q_data[3*(MW+1)+MW+1 -: MW+1]),
      .q_c1    (q_data[2*(MW+1)+MW+1 -: MW+1]),
      .q_c2    (q_data[(MW+1)+MW+1 -: MW+1]),
      .q_d     (q_data[MW+1:0]),
      .rsp_ch  (rsp_ch)
   );

endmodule

[hdl/vgu_front.sv]
// Front end: accept request beats, form the cross and dot product terms.
module vgu_front #(
   parameter int WORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   vgu_req_if.sink                       req_ch,
   output logic                          fr_valid,
   input  logic                          fr_ready,
   output logic [vgu_pkg::FUNC_WIDTH-1:0] fr_func,
   output logic signed [2*WORD_WIDTH:0]   fr_c0,
   output logic signed [2*WORD_WIDTH:0]   fr_c1,
   output logic signed [2*WORD_WIDTH:0]   fr_c2,
   output logic signed [2*WORD_WIDTH+1:0] fr_d
);

   localparam int PW = 2*WORD_WIDTH;

   logic                               s1_valid_ff, s1_valid_in;
   logic [vgu_pkg::FUNC_WIDTH-1:0]     s1_func_ff, s1_func_in;
   logic signed [WORD_WIDTH-1:0]       s1_a_ff [3];
   logic signed [WORD_WIDTH-1:0]       s1_a_in [3];
   logic signed [WORD_WIDTH-1:0]       s1_b_ff [3];
   logic signed [WORD_WIDTH-1:0]       s1_b_in [3];
   logic                               s2_valid_ff, s2_valid_in;
   logic [vgu_pkg::FUNC_WIDTH-1:0]     s2_func_ff, s2_func_in;
   logic signed [PW-1:0]               xp_ff [6];
   logic signed [PW-1:0]               xp_in [6];
   logic signed [PW-1:0]               dp_ff [3];
   logic signed [PW-1:0]               dp_in [3];
   logic                               s1_ready, s2_ready, mag_op;

   assign s2_ready     = !s2_valid_ff || fr_ready;
   assign s1_ready     = !s1_valid_ff || s2_ready;
   assign req_ch.ready = s1_ready;
   assign mag_op       = vgu_pkg::func_type'(req_ch.func) == vgu_pkg::FUNC_MAG;

   always_comb begin
      s1_valid_in = s1_ready ? req_ch.valid : s1_valid_ff;
      s1_func_in  = s1_func_ff;
      s1_a_in     = s1_a_ff;
      s1_b_in     = s1_b_ff;
      if (req_ch.valid && s1_ready) begin
         s1_func_in = req_ch.func;
         s1_a_in[0] = req_ch.ax;
         s1_a_in[1] = req_ch.ay;
         s1_a_in[2] = req_ch.az;
         s1_b_in[0] = mag_op ? req_ch.ax : req_ch.bx;
         s1_b_in[1] = mag_op ? req_ch.ay : req_ch.by;
         s1_b_in[2] = mag_op ? req_ch.az : req_ch.bz;
      end
   end

   always_comb begin
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
      s2_func_in  = s2_func_ff;
      xp_in       = xp_ff;
      dp_in       = dp_ff;
      if (s1_valid_ff && s2_ready) begin
         s2_func_in = s1_func_ff;
         xp_in[0]   = s1_a_ff[1] * s1_b_ff[2];
         xp_in[1]   = s1_a_ff[2] * s1_b_ff[1];
         xp_in[2]   = s1_a_ff[2] * s1_b_ff[0];
         xp_in[3]   = s1_a_ff[0] * s1_b_ff[2];
         xp_in[4]   = s1_a_ff[0] * s1_b_ff[1];
         xp_in[5]   = s1_a_ff[1] * s1_b_ff[0];
         dp_in[0]   = s1_a_ff[0] * s1_b_ff[0];
         dp_in[1]   = s1_a_ff[1] * s1_b_ff[1];
         dp_in[2]   = s1_a_ff[2] * s1_b_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_func_ff <= s1_func_in;
      s1_a_ff    <= s1_a_in;
      s1_b_ff    <= s1_b_in;
      s2_func_ff <= s2_func_in;
      xp_ff      <= xp_in;
      dp_ff      <= dp_in;
   end

   assign fr_valid = s2_valid_ff;
   assign fr_func  = s2_func_ff;
   assign fr_c0    = (PW+1)'(xp_ff[0]) - (PW+1)'(xp_ff[1]);
   assign fr_c1    = (PW+1)'(xp_ff[2]) - (PW+1)'(xp_ff[3]);
   assign fr_c2    = (PW+1)'(xp_ff[4]) - (PW+1)'(xp_ff[5]);
   assign fr_d     = (PW+2)'(dp_ff[0]) + (PW+2)'(dp_ff[1]) + (PW+2)'(dp_ff[2]);

endmodule

[hdl/vgu_queue.sv]
// Short first-in first-out queue between the front and back ends.
module vgu_queue #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_valid,
   output logic                  wr_ready,
   input  logic [DATA_WIDTH-1:0] wr_data,
   output logic                  rd_valid,
   input  logic                  rd_ready,
   output logic [DATA_WIDTH-1:0] rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]         wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  push, pop;

   assign wr_ready = count_ff != CW'(DEPTH);
   assign rd_valid = count_ff != '0;
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[hdl/vgu_back.sv]
// Back end: rounding and saturation, sum of squares, square root and division sequencer.
module vgu_back #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   output logic                           q_ready,
   input  logic [vgu_pkg::FUNC_WIDTH-1:0] q_func,
   input  logic signed [2*WORD_WIDTH:0]   q_c0,
   input  logic signed [2*WORD_WIDTH:0]   q_c1,
   input  logic signed [2*WORD_WIDTH:0]   q_c2,
   input  logic signed [2*WORD_WIDTH+1:0] q_d,
   vgu_rsp_if.source                      rsp_ch
);

   localparam int W  = WORD_WIDTH;
   localparam int MW = 2*W;
   localparam int QW = 4*W;
   localparam int NB = MW + FRAC_BITS;
   localparam int RW = MW + 1;
   localparam int SW = NB + 1;
   localparam int CW = $clog2(NB);
   localparam int IW = $clog2(MW);
   localparam logic [SW-1:0] HALF = SW'(1) << (FRAC_BITS-1);

   function automatic logic [W:0] sat_word(input logic [SW-1:0] mag, input logic neg);
      logic [SW-1:0] lim;
      logic          over;
      logic [W-1:0]  word;
      lim  = (SW'(1) << (W-1)) - SW'(!neg);
      over = mag > lim;
      word = over ? lim[W-1:0] : mag[W-1:0];
      if (neg) begin
         word = -word;
      end
      return {over, word};
   endfunction

   vgu_pkg::back_state_type state_ff, state_in;
   vgu_pkg::func_type       func_ff, func_in;
   logic [CW-1:0]           step_ff, step_in;
   logic                    neg_ff [3];
   logic                    neg_in [3];
   logic [MW-1:0]           mag_ff [3];
   logic [MW-1:0]           mag_in [3];
   logic [MW-1:0]           div_ff, div_in;
   logic [QW-1:0]           sq_ff, sq_in;
   logic [MW-1:0]           root_ff, root_in;
   logic [RW-1:0]           srem_ff, srem_in;
   logic [NB-1:0]           num_ff [3];
   logic [NB-1:0]           num_in [3];
   logic [MW-1:0]           rem_ff [3];
   logic [MW-1:0]           rem_in [3];
   logic signed [W-1:0]     word_ff [3];
   logic signed [W-1:0]     word_in [3];
   vgu_pkg::status_type     status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic signed [MW:0]      hd_c [3];
   logic signed [MW:0]      hd_abs [3];
   logic [MW-1:0]           hd_cm [3];
   logic                    hd_cneg [3];
   logic signed [MW+1:0]    hd_dabs;
   logic [MW-1:0]           hd_dm;
   logic                    hd_dneg;
   vgu_pkg::func_type       hd_func;
   logic                    hd_fast;
   logic [W-1:0]            fast_word [3];
   vgu_pkg::status_type     fast_status;
   logic [W-1:0]            slow_word [3];
   vgu_pkg::status_type     slow_status;
   logic                    out_free, out_load, out_slow, start;

   assign hd_c[0] = q_c0;
   assign hd_c[1] = q_c1;
   assign hd_c[2] = q_c2;
   assign hd_func = vgu_pkg::func_type'(q_func);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         hd_cneg[i] = hd_c[i][MW];
         hd_abs[i]  = hd_cneg[i] ? -hd_c[i] : hd_c[i];
         hd_cm[i]   = hd_abs[i][MW-1:0];
      end
      hd_dneg = q_d[MW+1];
      hd_dabs = hd_dneg ? -q_d : q_d;
      hd_dm   = hd_dabs[MW-1:0];
   end

   // cross, dot, unknown codes and zero divisors finish straight from the queue head
   always_comb begin
      logic [SW-1:0] t;
      logic [W:0]    s;
      logic          flag;
      hd_fast     = 1'b1;
      fast_status = vgu_pkg::STATUS_OK;
      flag        = 1'b0;
      t           = '0;
      s           = '0;
      for (int i = 0; i < 3; i++) begin
         fast_word[i] = '0;
      end
      unique case (hd_func)
         vgu_pkg::FUNC_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               t            = (SW'(hd_cm[i]) + HALF) >> FRAC_BITS;
               s            = sat_word(t, hd_cneg[i] && (t != '0));
               fast_word[i] = s[W-1:0];
               flag         = flag | s[W];
            end
         end
         vgu_pkg::FUNC_DOT: begin
            t            = (SW'(hd_dm) + HALF) >> FRAC_BITS;
            s            = sat_word(t, hd_dneg && (t != '0));
            fast_word[0] = s[W-1:0];
            flag         = s[W];
         end
         vgu_pkg::FUNC_NORM: begin
            if (hd_cm[0] == '0 && hd_cm[1] == '0 && hd_cm[2] == '0) begin
               fast_status = vgu_pkg::STATUS_ZERO_DIV;
            end else begin
               hd_fast = 1'b0;
            end
         end
         vgu_pkg::FUNC_TAN: begin
            if (hd_dm == '0) begin
               fast_status = vgu_pkg::STATUS_ZERO_DIV;
            end else begin
               hd_fast = 1'b0;
            end
         end
         vgu_pkg::FUNC_MAG: hd_fast = 1'b0;
         default: ;
      endcase
      if (flag) begin
         fast_status = vgu_pkg::STATUS_SAT;
      end
   end

   always_comb begin
      logic [SW-1:0] t;
      logic [W:0]    s;
      logic          flag;
      slow_status = vgu_pkg::STATUS_OK;
      flag        = 1'b0;
      t           = '0;
      s           = '0;
      for (int i = 0; i < 3; i++) begin
         slow_word[i] = '0;
      end
      case (func_ff)
         vgu_pkg::FUNC_MAG: begin
            t            = SW'(root_ff) + SW'(srem_ff > RW'(root_ff));
            s            = sat_word(t, 1'b0);
            slow_word[0] = s[W-1:0];
            flag         = s[W];
         end
         vgu_pkg::FUNC_NORM: begin
            for (int i = 0; i < 3; i++) begin
               t            = SW'(num_ff[i]) + SW'({rem_ff[i], 1'b0} >= {1'b0, div_ff});
               s            = sat_word(t, neg_ff[i] && (t != '0));
               slow_word[i] = s[W-1:0];
               flag         = flag | s[W];
            end
         end
         vgu_pkg::FUNC_TAN: begin
            t            = SW'(num_ff[0]) + SW'({rem_ff[0], 1'b0} >= {1'b0, div_ff});
            s            = sat_word(t, neg_ff[0] && (t != '0));
            slow_word[0] = s[W-1:0];
            flag         = s[W];
         end
         default: ;
      endcase
      if (flag) begin
         slow_status = vgu_pkg::STATUS_SAT;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vgu_pkg::BACK_IDLE: begin
            if (q_valid && !hd_fast) begin
               state_in = (hd_func == vgu_pkg::FUNC_MAG) ? vgu_pkg::BACK_ROOT
                                                         : vgu_pkg::BACK_SQUARE;
            end
         end
         vgu_pkg::BACK_SQUARE: begin
            if (step_ff == '0) begin
               state_in = vgu_pkg::BACK_ROOT;
            end
         end
         vgu_pkg::BACK_ROOT: begin
            if (step_ff == '0) begin
               state_in = (func_ff == vgu_pkg::FUNC_MAG) ? vgu_pkg::BACK_OUTPUT
                                                         : vgu_pkg::BACK_PREP;
            end
         end
         vgu_pkg::BACK_PREP: state_in = vgu_pkg::BACK_DIVIDE;
         vgu_pkg::BACK_DIVIDE: begin
            if (step_ff == '0) begin
               state_in = vgu_pkg::BACK_OUTPUT;
            end
         end
         vgu_pkg::BACK_OUTPUT: begin
            if (out_free) begin
               state_in = vgu_pkg::BACK_IDLE;
            end
         end
         default: state_in = vgu_pkg::BACK_IDLE;
      endcase
   end

   always_comb begin
      q_ready  = 1'b0;
      out_load = 1'b0;
      out_slow = 1'b0;
      start    = 1'b0;
      unique case (state_ff)
         vgu_pkg::BACK_IDLE: begin
            if (q_valid) begin
               if (hd_fast) begin
                  q_ready  = out_free;
                  out_load = out_free;
               end else begin
                  q_ready = 1'b1;
                  start   = 1'b1;
               end
            end
         end
         vgu_pkg::BACK_OUTPUT: begin
            out_load = out_free;
            out_slow = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      logic [IW-1:0]   idx;
      logic [MW+1:0]   bitsum;
      logic [RW+1:0]   r_sh;
      logic [RW+1:0]   trial;
      logic            ge;
      logic [MW:0]     d_sh;
      logic            d_ge;
      func_in  = func_ff;
      step_in  = step_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      div_in   = div_ff;
      sq_in    = sq_ff;
      root_in  = root_ff;
      srem_in  = srem_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      idx      = step_ff[IW-1:0];
      bitsum   = '0;
      r_sh     = '0;
      trial    = '0;
      ge       = 1'b0;
      d_sh     = '0;
      d_ge     = 1'b0;
      case (state_ff)
         vgu_pkg::BACK_IDLE: begin
            if (start) begin
               func_in = hd_func;
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = hd_cm[i];
                  neg_in[i] = hd_cneg[i];
               end
               if (hd_func == vgu_pkg::FUNC_TAN) begin
                  neg_in[0] = hd_dneg;
               end
               div_in  = hd_dm;
               sq_in   = (hd_func == vgu_pkg::FUNC_MAG) ? QW'(hd_dm) : '0;
               root_in = '0;
               srem_in = '0;
               step_in = CW'(MW-1);
            end
         end
         vgu_pkg::BACK_SQUARE: begin
            for (int i = 0; i < 3; i++) begin
               bitsum = bitsum + (mag_ff[i][idx] ? (MW+2)'(mag_ff[i]) : '0);
            end
            sq_in   = {sq_ff[QW-2:0], 1'b0} + QW'(bitsum);
            step_in = (step_ff == '0) ? CW'(MW-1) : step_ff - CW'(1);
         end
         vgu_pkg::BACK_ROOT: begin
            r_sh    = {srem_ff, sq_ff[QW-1:QW-2]};
            trial   = (RW+2)'({root_ff, 2'b01});
            ge      = r_sh >= trial;
            srem_in = ge ? RW'(r_sh - trial) : r_sh[RW-1:0];
            root_in = {root_ff[MW-2:0], ge};
            sq_in   = {sq_ff[QW-3:0], 2'b00};
            step_in = step_ff - CW'(1);
         end
         vgu_pkg::BACK_PREP: begin
            if (func_ff == vgu_pkg::FUNC_NORM) begin
               div_in = root_ff;
               for (int i = 0; i < 3; i++) begin
                  num_in[i] = {mag_ff[i], {FRAC_BITS{1'b0}}};
               end
            end else begin
               num_in[0] = {root_ff, {FRAC_BITS{1'b0}}};
               num_in[1] = '0;
               num_in[2] = '0;
            end
            for (int i = 0; i < 3; i++) begin
               rem_in[i] = '0;
            end
            step_in = CW'(NB-1);
         end
         vgu_pkg::BACK_DIVIDE: begin
            for (int i = 0; i < 3; i++) begin
               d_sh      = {rem_ff[i], num_ff[i][NB-1]};
               d_ge      = d_sh >= {1'b0, div_ff};
               rem_in[i] = d_ge ? MW'(d_sh - {1'b0, div_ff}) : d_sh[MW-1:0];
               num_in[i] = {num_ff[i][NB-2:0], d_ge};
            end
            step_in = step_ff - CW'(1);
         end
         default: ;
      endcase
   end

   always_comb begin
      word_in      = word_ff;
      status_in    = status_ff;
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ch.ready);
      if (out_load) begin
         for (int i = 0; i < 3; i++) begin
            word_in[i] = out_slow ? slow_word[i] : fast_word[i];
         end
         status_in = out_slow ? slow_status : fast_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vgu_pkg::BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff   <= func_in;
      step_ff   <= step_in;
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      div_ff    <= div_in;
      sq_ff     <= sq_in;
      root_ff   <= root_in;
      srem_ff   <= srem_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      word_ff   <= word_in;
      status_ff <= status_in;
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.rx     = word_ff[0];
   assign rsp_ch.ry     = word_ff[1];
   assign rsp_ch.rz     = word_ff[2];
   assign rsp_ch.status = status_ff;

endmodule
